// File: hw/rtl/qapm_pkg.sv
`default_nettype none

package qapm_pkg;

  // Fixed-point scaling: one unit is 1024 in the Q10 formats.
  localparam int Q_ONE     = 1024;
  localparam int MOTOR_MIN = 5 * Q_ONE;
  localparam int MOTOR_MAX = 131071;

  // Stream payload widths.
  localparam int IN_W  = 144;
  localparam int OUT_W = 72;

  // Gain register layout and reset values (kp, ki, kd from the top down).
  localparam int GAIN_W = 20;
  localparam int REG_W  = 3 * GAIN_W;
  localparam logic [REG_W-1:0] ROLL_GAINS_RST  = {20'd15729, 20'd786, 20'd131};
  localparam logic [REG_W-1:0] PITCH_GAINS_RST = {20'd19661, 20'd786, 20'd131};
  localparam logic [REG_W-1:0] YAW_GAINS_RST   = {20'd13107, 20'd0, 20'd0};

  // Shared multiply/divide unit.
  localparam int MDU_W     = 64;
  localparam int MDU_B_W   = 20;
  localparam int MUL_STEPS = 20;
  localparam int DIV_STEPS = 48;
  localparam int CNT_W     = 6;

  typedef enum logic [1:0] {
    REG_ROLL_GAINS  = 2'd0,
    REG_PITCH_GAINS = 2'd1,
    REG_YAW_GAINS   = 2'd2
  } cfg_reg_e;

  typedef enum logic [1:0] {
    AXIS_ROLL  = 2'd0,
    AXIS_PITCH = 2'd1,
    AXIS_YAW   = 2'd2
  } axis_e;

  typedef enum logic {
    MDU_MUL = 1'b0,
    MDU_DIV = 1'b1
  } mdu_op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_AXIS,
    ST_MUL_EDT,
    ST_MUL_KI,
    ST_MUL_KP,
    ST_MUL_KD,
    ST_DIV,
    ST_SUM,
    ST_MIX,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic               start;
    mdu_op_e            op;
    logic [MDU_W-1:0]   opa;
    logic [MDU_B_W-1:0] opb;
  } mdu_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [MDU_W-1:0] result;
  } mdu_rsp_t;

endpackage

`default_nettype wire

// File: hw/rtl/quad_attitude_pid_mixer_top.sv
`default_nettype none

// Channel     Direction  Handshake                      Payload
// s_axis      in         s_axis_tvalid/s_axis_tready    one sensor and stick sample
// m_axis      out        m_axis_tvalid/m_axis_tready    four motor drive values
// cfg         in         cfg_we_i                       gain register write
//
// A sample with throttle below 5 percent skips the loops. Otherwise each loop
// runs four multiplies and one divide on the one bit-serial multiply/divide
// unit; the yaw loop runs only while the yaw stick is in its center band.
// Reset restores the gain registers and clears the loop state. A new request
// is taken while a finished result still waits in the output register.
module quad_attitude_pid_mixer_top
  import qapm_pkg::*;
#(
  parameter int MAX_TURN = 15
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             s_axis_tvalid,
  output logic                  s_axis_tready,
  // throttle, roll_setpoint, pitch_setpoint, yaw_command, measured_roll,
  // measured_pitch, measured_yaw, sample_interval
  input  wire logic [IN_W-1:0]  s_axis_tdata,
  output logic                  m_axis_tvalid,
  input  wire logic             m_axis_tready,
  // motor_left_front, motor_right_front, motor_left_rear, motor_right_rear
  output logic [OUT_W-1:0]      m_axis_tdata,
  input  wire logic             cfg_we_i,
  input  wire logic [1:0]       cfg_idx_i,
  input  wire logic [REG_W-1:0] cfg_wdata_i
);

  localparam int LIM = MAX_TURN * Q_ONE;
  localparam logic signed [19:0] LIM_S = 20'(LIM);

  state_e state_q, state_d;
  axis_e  axis_q, axis_d;
  logic [1:0] mix_q, mix_d;

  logic [REG_W-1:0] gains_q [3];
  logic signed [17:0] integ_q [3];
  logic signed [17:0] integ_d [3];
  logic signed [20:0] last_q [3];
  logic signed [20:0] last_d [3];
  logic signed [18:0] held_q, held_d;
  logic cap_q, cap_d;

  logic [16:0] thr_q;
  logic signed [18:0] rsp_q, psp_q, mr_q, mp_q, my_q;
  logic signed [11:0] ycmd_q;
  logic [19:0] dt_q;

  logic signed [20:0] e_q, e_d;
  logic signed [20:0] diff_q, diff_d;
  logic signed [17:0] inew_q, inew_d;
  logic signed [23:0] p_q, p_d;
  logic signed [45:0] d_q, d_d;
  logic signed [19:0] term_q [3];
  logic signed [19:0] term_d [3];
  logic [16:0] mot_q [4];
  logic [16:0] mot_d [4];

  logic out_valid_q, out_valid_d;
  logic [67:0] out_data_q, out_data_d;

  mdu_req_t mdu_req;
  mdu_rsp_t mdu_rsp;

  logic in_acc;
  logic [REG_W-1:0] gsel;
  logic signed [18:0] held_nx;
  logic signed [20:0] e_c;
  logic signed [19:0] ymul;
  logic yaw_band;
  logic signed [25:0] isum;
  logic signed [47:0] tsum;
  logic signed [21:0] mval;
  logic signed [21:0] thr_s, r_s, p_s, y_s;
  logic [18:0] cap_lim;

  function automatic logic signed [19:0] sat_turn(input logic signed [47:0] v);
    logic signed [47:0] r;
    begin
      r = v;
      if (v > 48'(LIM)) r = 48'(LIM);
      if (v < -48'(LIM)) r = -48'(LIM);
      return r[19:0];
    end
  endfunction

  function automatic logic [19:0] mag21(input logic signed [20:0] v);
    logic signed [20:0] a;
    begin
      a = (v < 0) ? -v : v;
      return a[19:0];
    end
  endfunction

  function automatic logic [16:0] motor_fix(input logic signed [21:0] m,
                                            input logic [18:0] cap);
    logic signed [21:0] v;
    begin
      v = m;
      if (v < MOTOR_MIN) v = '0;
      if (v > $signed({3'b000, cap})) v = $signed({3'b000, cap});
      if (v > MOTOR_MAX) v = 22'(MOTOR_MAX);
      return v[16:0];
    end
  endfunction

  qapm_mdu u_mdu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mdu_req),
    .rsp_o  (mdu_rsp)
  );

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0000, out_data_q};

  // Per-axis operands.
  assign gsel    = gains_q[axis_q];
  assign ymul    = 20'(ycmd_q) * $signed(20'(MAX_TURN));
  assign yaw_band = (ymul >= -20'(Q_ONE)) && (ymul <= 20'(Q_ONE));
  assign held_nx = cap_q ? my_q : held_q;
  assign cap_lim = 19'(thr_q) + 19'(LIM);

  always_comb begin
    case (axis_q)
      AXIS_ROLL:  e_c = -21'(rsp_q) - 21'(mr_q);
      AXIS_PITCH: e_c = 21'(psp_q) - 21'(mp_q);
      AXIS_YAW:   e_c = 21'(held_nx) - 21'(my_q);
      default:    e_c = '0;
    endcase
  end

  // Mixer operands for the motor selected by mix_q.
  assign thr_s = $signed({5'b00000, thr_q});
  assign r_s   = 22'(term_q[AXIS_ROLL]);
  assign p_s   = 22'(term_q[AXIS_PITCH]);
  assign y_s   = 22'(term_q[AXIS_YAW]);

  always_comb begin
    case (mix_q)
      2'd0:    mval = thr_s - p_s - r_s - y_s;
      2'd1:    mval = thr_s - p_s + r_s + y_s;
      2'd2:    mval = thr_s + p_s - r_s + y_s;
      2'd3:    mval = thr_s + p_s + r_s - y_s;
      default: mval = thr_s;
    endcase
  end

  assign isum = 26'(integ_q[axis_q]) +
                ((e_q < 0) ? -26'(mdu_rsp.result[60:37]) : 26'(mdu_rsp.result[60:37]));
  assign tsum = 48'(p_q) + 48'(inew_q) + 48'(d_q);

  // Sequencer: next state, unit requests and loop state updates.
  always_comb begin
    state_d     = state_q;
    axis_d      = axis_q;
    mix_d       = mix_q;
    held_d      = held_q;
    cap_d       = cap_q;
    e_d         = e_q;
    diff_d      = diff_q;
    inew_d      = inew_q;
    p_d         = p_q;
    d_d         = d_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    for (int i = 0; i < 3; i++) begin
      integ_d[i] = integ_q[i];
      last_d[i]  = last_q[i];
      term_d[i]  = term_q[i];
    end
    for (int i = 0; i < 4; i++) begin
      mot_d[i] = mot_q[i];
    end
    mdu_req.start = 1'b0;
    mdu_req.op    = MDU_MUL;
    mdu_req.opa   = '0;
    mdu_req.opb   = '0;

    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (s_axis_tdata[16:0] < 17'(MOTOR_MIN)) begin
            // Motors off: clear integrators and previous errors.
            for (int i = 0; i < 3; i++) begin
              integ_d[i] = '0;
              last_d[i]  = '0;
            end
            for (int i = 0; i < 4; i++) begin
              mot_d[i] = '0;
            end
            state_d = ST_DONE;
          end else begin
            axis_d  = AXIS_ROLL;
            state_d = ST_AXIS;
          end
        end
      end
      ST_AXIS: begin
        if (axis_q == AXIS_YAW && !yaw_band) begin
          // Yaw stick outside the center band drives the yaw term directly.
          cap_d                = 1'b1;
          term_d[AXIS_YAW]     = ymul;
          mix_d                = 2'd0;
          state_d              = ST_MIX;
        end else begin
          if (axis_q == AXIS_YAW) begin
            held_d = held_nx;
            cap_d  = 1'b0;
          end
          e_d           = e_c;
          diff_d        = 21'(22'(e_c) - 22'(last_q[axis_q]));
          mdu_req.start = 1'b1;
          mdu_req.op    = MDU_MUL;
          mdu_req.opa   = MDU_W'(mag21(e_c));
          mdu_req.opb   = dt_q;
          state_d       = ST_MUL_EDT;
        end
      end
      ST_MUL_EDT: begin
        if (mdu_rsp.done) begin
          mdu_req.start = 1'b1;
          mdu_req.op    = MDU_MUL;
          mdu_req.opa   = mdu_rsp.result;
          mdu_req.opb   = gsel[39:20];
          state_d       = ST_MUL_KI;
        end
      end
      ST_MUL_KI: begin
        if (mdu_rsp.done) begin
          inew_d        = 18'(sat_turn(48'(isum)));
          mdu_req.start = 1'b1;
          mdu_req.op    = MDU_MUL;
          mdu_req.opa   = MDU_W'(mag21(e_q));
          mdu_req.opb   = gsel[59:40];
          state_d       = ST_MUL_KP;
        end
      end
      ST_MUL_KP: begin
        if (mdu_rsp.done) begin
          p_d = (e_q < 0) ? -24'(mdu_rsp.result[39:17]) : 24'(mdu_rsp.result[39:17]);
          mdu_req.start = 1'b1;
          mdu_req.op    = MDU_MUL;
          mdu_req.opa   = MDU_W'(mag21(diff_q));
          mdu_req.opb   = gsel[19:0];
          state_d       = ST_MUL_KD;
        end
      end
      ST_MUL_KD: begin
        if (mdu_rsp.done) begin
          mdu_req.start = 1'b1;
          mdu_req.op    = MDU_DIV;
          mdu_req.opa   = mdu_rsp.result << 3;
          mdu_req.opb   = dt_q;
          state_d       = ST_DIV;
        end
      end
      ST_DIV: begin
        if (mdu_rsp.done) begin
          d_d = (diff_q < 0) ? -46'(mdu_rsp.result[43:0]) : 46'(mdu_rsp.result[43:0]);
          state_d = ST_SUM;
        end
      end
      ST_SUM: begin
        term_d[axis_q]  = sat_turn(tsum);
        integ_d[axis_q] = inew_q;
        last_d[axis_q]  = e_q;
        case (axis_q)
          AXIS_ROLL: begin
            axis_d  = AXIS_PITCH;
            state_d = ST_AXIS;
          end
          AXIS_PITCH: begin
            axis_d  = AXIS_YAW;
            state_d = ST_AXIS;
          end
          default: begin
            mix_d   = 2'd0;
            state_d = ST_MIX;
          end
        endcase
      end
      ST_MIX: begin
        mot_d[mix_q] = motor_fix(mval, cap_lim);
        mix_d        = mix_q + 1'b1;
        if (mix_q == 2'd3) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_data_d  = {mot_q[3], mot_q[2], mot_q[1], mot_q[0]};
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control and loop state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      axis_q      <= AXIS_ROLL;
      mix_q       <= '0;
      held_q      <= '0;
      cap_q       <= 1'b1;
      out_valid_q <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        integ_q[i] <= '0;
        last_q[i]  <= '0;
      end
    end else begin
      state_q     <= state_d;
      axis_q      <= axis_d;
      mix_q       <= mix_d;
      held_q      <= held_d;
      cap_q       <= cap_d;
      out_valid_q <= out_valid_d;
      for (int i = 0; i < 3; i++) begin
        integ_q[i] <= integ_d[i];
        last_q[i]  <= last_d[i];
      end
    end
  end

  // Gain registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gains_q[REG_ROLL_GAINS]  <= ROLL_GAINS_RST;
      gains_q[REG_PITCH_GAINS] <= PITCH_GAINS_RST;
      gains_q[REG_YAW_GAINS]   <= YAW_GAINS_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_ROLL_GAINS:  gains_q[REG_ROLL_GAINS]  <= cfg_wdata_i;
        REG_PITCH_GAINS: gains_q[REG_PITCH_GAINS] <= cfg_wdata_i;
        REG_YAW_GAINS:   gains_q[REG_YAW_GAINS]   <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  // Sample capture; a zero interval counts as one.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      thr_q  <= s_axis_tdata[16:0];
      rsp_q  <= s_axis_tdata[35:17];
      psp_q  <= s_axis_tdata[54:36];
      ycmd_q <= s_axis_tdata[66:55];
      mr_q   <= s_axis_tdata[85:67];
      mp_q   <= s_axis_tdata[104:86];
      my_q   <= s_axis_tdata[123:105];
      dt_q   <= (s_axis_tdata[143:124] == '0) ? 20'd1 : s_axis_tdata[143:124];
    end
  end

  // Working registers.
  always_ff @(posedge clk_i) begin
    e_q        <= e_d;
    diff_q     <= diff_d;
    inew_q     <= inew_d;
    p_q        <= p_d;
    d_q        <= d_d;
    out_data_q <= out_data_d;
    for (int i = 0; i < 3; i++) begin
      term_q[i] <= term_d[i];
    end
    for (int i = 0; i < 4; i++) begin
      mot_q[i] <= mot_d[i];
    end
  end

`ifndef SYNTH
  a_idle_unit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !mdu_rsp.busy)
    else $error("arithmetic unit busy while waiting for a request");

  a_unit_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mdu_rsp.done |-> (state_q == ST_MUL_EDT || state_q == ST_MUL_KI ||
                      state_q == ST_MUL_KP || state_q == ST_MUL_KD || state_q == ST_DIV))
    else $error("arithmetic result arrived outside a wait state");

  a_off_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && s_axis_tdata[16:0] < 17'(MOTOR_MIN)) |=>
      (integ_q[0] == 0 && integ_q[1] == 0 && integ_q[2] == 0 &&
       last_q[0] == 0 && last_q[1] == 0 && last_q[2] == 0))
    else $error("low throttle did not clear loop state");

  a_integ_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (integ_q[0] <= LIM_S && integ_q[0] >= -LIM_S &&
     integ_q[1] <= LIM_S && integ_q[1] >= -LIM_S &&
     integ_q[2] <= LIM_S && integ_q[2] >= -LIM_S))
    else $error("integrator outside its saturation range");
`endif

endmodule

`default_nettype wire

// File: hw/rtl/qapm_mdu.sv
`default_nettype none

// Bit-serial unsigned multiply (shift-add) and restoring divide.
module qapm_mdu
  import qapm_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire mdu_req_t req_i,
  output mdu_rsp_t      rsp_o
);

  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  mdu_op_e            op_q, op_d;
  logic [MDU_W-1:0]   acc_q, acc_d;
  logic [MDU_W-1:0]   sh_q, sh_d;
  logic [MDU_B_W-1:0] opb_q, opb_d;
  logic [MDU_B_W-1:0] rem_q, rem_d;
  logic [MDU_B_W:0]   trial;
  logic               ge;

  // Divide step: shift the next dividend bit into the partial remainder.
  assign trial = {rem_q, acc_q[DIV_STEPS-1]};
  assign ge    = trial >= {1'b0, opb_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    op_d   = op_q;
    acc_d  = acc_q;
    sh_d   = sh_q;
    opb_d  = opb_q;
    rem_d  = rem_q;
    if (!busy_q) begin
      if (req_i.start) begin
        busy_d = 1'b1;
        op_d   = req_i.op;
        opb_d  = req_i.opb;
        rem_d  = '0;
        sh_d   = req_i.opa;
        if (req_i.op == MDU_MUL) begin
          acc_d = '0;
          cnt_d = CNT_W'(MUL_STEPS);
        end else begin
          acc_d = {{(MDU_W-DIV_STEPS){1'b0}}, req_i.opa[DIV_STEPS-1:0]};
          cnt_d = CNT_W'(DIV_STEPS);
        end
      end
    end else begin
      case (op_q)
        MDU_MUL: begin
          if (opb_q[0]) begin
            acc_d = acc_q + sh_q;
          end
          sh_d  = sh_q << 1;
          opb_d = opb_q >> 1;
        end
        MDU_DIV: begin
          acc_d = {{(MDU_W-DIV_STEPS){1'b0}}, acc_q[DIV_STEPS-2:0], ge};
          rem_d = ge ? MDU_B_W'(trial - {1'b0, opb_q}) : trial[MDU_B_W-1:0];
        end
        default: begin
          acc_d = acc_q;
        end
      endcase
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q  <= op_d;
    acc_q <= acc_d;
    sh_q  <= sh_d;
    opb_q <= opb_d;
    rem_q <= rem_d;
  end

  assign rsp_o.busy   = busy_q;
  assign rsp_o.done   = done_q;
  assign rsp_o.result = acc_q;

endmodule

`default_nettype wire

// File: sim/quad_attitude_pid_mixer_top_tb.sv
`default_nettype none

module quad_attitude_pid_mixer_top_tb;
  import qapm_pkg::*;

  localparam int TURN      = 15;
  localparam int LIM       = TURN * 1024;
  localparam int WATCHDOG  = 20000;
  localparam int ANG_MAX   = 184320;

  typedef struct packed {
    logic [19:0] sample_interval;
    logic [18:0] measured_yaw;
    logic [18:0] measured_pitch;
    logic [18:0] measured_roll;
    logic [11:0] yaw_command;
    logic [18:0] pitch_setpoint;
    logic [18:0] roll_setpoint;
    logic [16:0] throttle;
  } sample_t;

  typedef struct packed {
    logic [16:0] right_rear;
    logic [16:0] left_rear;
    logic [16:0] right_front;
    logic [16:0] left_front;
  } motors_t;

  logic clk_i;
  logic rst_ni;
  logic s_axis_tvalid;
  logic s_axis_tready;
  logic [IN_W-1:0] s_axis_tdata;
  logic m_axis_tvalid;
  logic m_axis_tready;
  logic [OUT_W-1:0] m_axis_tdata;
  logic cfg_we_i;
  logic [1:0] cfg_idx_i;
  logic [REG_W-1:0] cfg_wdata_i;

  quad_attitude_pid_mixer_top #(.MAX_TURN(TURN)) u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i), .cfg_wdata_i(cfg_wdata_i)
  );

  // Controller state mirrored for prediction.
  logic [REG_W-1:0] gains_q [3];
  longint integ_q [3];
  longint last_err_q [3];
  longint heading_q;
  bit capture_q;

  sample_t pending_samples[$];
  motors_t expected_motors[$];
  int send_idle_pct, recv_stall_pct;
  int hold_off_cycles;
  int errors, samples_sent, results_seen, quiet_cycles;
  bit in_taken;

  always begin
    clk_i = 1'b1; #1;
    clk_i = 1'b0; #1;
  end

  function automatic longint div_tz(longint v, int s);
    longint m;
    m = (v < 0) ? -v : v;
    m = m >>> s;
    return (v < 0) ? -m : m;
  endfunction

  function automatic longint clamp_turn(longint v);
    if (v > LIM) return LIM;
    if (v < -LIM) return -LIM;
    return v;
  endfunction

  function automatic longint run_axis(int ax, longint e, longint dt);
    longint kp, ki, kd, i, p, d;
    kp = gains_q[ax][59:40];
    ki = gains_q[ax][39:20];
    kd = gains_q[ax][19:0];
    i = clamp_turn(integ_q[ax] + div_tz(e * dt * ki, 37));
    p = div_tz(kp * e, 17);
    d = (kd * (e - last_err_q[ax]) * 8) / dt;
    integ_q[ax] = i;
    last_err_q[ax] = e;
    return clamp_turn(p + i + d);
  endfunction

  function automatic logic [16:0] limit_motor(longint m, longint cap);
    if (m < MOTOR_MIN) m = 0;
    if (m > cap) m = cap;
    if (m > MOTOR_MAX) m = MOTOR_MAX;
    return m[16:0];
  endfunction

  // Predict the four motor drives for one accepted sample.
  function automatic motors_t mix_motors(sample_t s);
    longint thr, dt, r, p, y, my, cap;
    motors_t m;
    thr = s.throttle;
    dt = (s.sample_interval == 0) ? 1 : s.sample_interval;
    my = $signed(s.measured_yaw);
    if (thr < MOTOR_MIN) begin
      for (int a = 0; a < 3; a++) begin
        integ_q[a] = 0;
        last_err_q[a] = 0;
      end
      return '0;
    end
    r = run_axis(AXIS_ROLL, -longint'($signed(s.roll_setpoint))
                 - longint'($signed(s.measured_roll)), dt);
    p = run_axis(AXIS_PITCH, longint'($signed(s.pitch_setpoint))
                 - longint'($signed(s.measured_pitch)), dt);
    y = longint'($signed(s.yaw_command)) * TURN;
    if (y >= -Q_ONE && y <= Q_ONE) begin
      if (capture_q) heading_q = my;
      capture_q = 0;
      y = run_axis(AXIS_YAW, heading_q - my, dt);
    end else begin
      capture_q = 1;
    end
    cap = thr + LIM;
    m.left_front  = limit_motor(thr - p - r - y, cap);
    m.right_front = limit_motor(thr - p + r + y, cap);
    m.left_rear   = limit_motor(thr + p - r + y, cap);
    m.right_rear  = limit_motor(thr + p + r - y, cap);
    return m;
  endfunction

  function automatic logic [18:0] rand_angle();
    return 19'($signed($urandom_range(0, 2 * ANG_MAX)) - ANG_MAX);
  endfunction

  function automatic sample_t rand_sample(bit steady);
    sample_t s;
    int k;
    s.throttle = ($urandom_range(0, 9) == 0) ? 17'($urandom_range(0, 5200))
                 : 17'($urandom_range(5120, 102400));
    s.roll_setpoint = steady ? 19'($signed($urandom_range(0, 20480)) - 10240) : rand_angle();
    s.pitch_setpoint = steady ? 19'($signed($urandom_range(0, 20480)) - 10240) : rand_angle();
    k = $urandom_range(0, 3);
    s.yaw_command = (k == 0) ? 12'($signed($urandom_range(0, 2048)) - 1024)
                    : 12'($signed($urandom_range(0, 136)) - 68);
    s.measured_roll = steady ? 19'($signed($urandom_range(0, 20480)) - 10240) : rand_angle();
    s.measured_pitch = steady ? 19'($signed($urandom_range(0, 20480)) - 10240) : rand_angle();
    s.measured_yaw = rand_angle();
    k = $urandom_range(0, 9);
    s.sample_interval = (k == 0) ? 20'($urandom_range(0, 3))
                        : (k == 1) ? 20'($urandom_range(0, 1048575))
                        : 20'($urandom_range(512, 2048));
    return s;
  endfunction

  function automatic sample_t make_sample(int thr, int rsp, int psp, int ycmd,
                                          int mr, int mp, int my, int dt);
    sample_t s;
    s.throttle = 17'(thr);
    s.roll_setpoint = 19'(rsp);
    s.pitch_setpoint = 19'(psp);
    s.yaw_command = 12'(ycmd);
    s.measured_roll = 19'(mr);
    s.measured_pitch = 19'(mp);
    s.measured_yaw = 19'(my);
    s.sample_interval = 20'(dt);
    return s;
  endfunction

  // Request driver: offers the queued samples, idling at random.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!s_axis_tvalid || in_taken) begin
        if (pending_samples.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          s_axis_tdata <= pending_samples.pop_front();
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result receiver: random readiness, plus a counted hold-off on demand.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_off_cycles > 0) begin
        hold_off_cycles--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  // Request tracking, result monitor and watchdog.
  always @(posedge clk_i) begin
    motors_t got, exp_m;
    in_taken = s_axis_tvalid && s_axis_tready;
    if (rst_ni) begin
      if (in_taken) begin
        expected_motors.push_back(mix_motors(sample_t'(s_axis_tdata)));
        samples_sent++;
      end
      if (in_taken || (m_axis_tvalid && m_axis_tready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[67:0];
        results_seen++;
        if (expected_motors.size() == 0) begin
          $display("%0t: unexpected result %h", $time, got);
          errors++;
        end else begin
          exp_m = expected_motors.pop_front();
          if (got.left_front !== exp_m.left_front)
            $display("%0t: left front expected %0d got %0d", $time,
                     exp_m.left_front, got.left_front);
          if (got.right_front !== exp_m.right_front)
            $display("%0t: right front expected %0d got %0d", $time,
                     exp_m.right_front, got.right_front);
          if (got.left_rear !== exp_m.left_rear)
            $display("%0t: left rear expected %0d got %0d", $time,
                     exp_m.left_rear, got.left_rear);
          if (got.right_rear !== exp_m.right_rear)
            $display("%0t: right rear expected %0d got %0d", $time,
                     exp_m.right_rear, got.right_rear);
          if (got !== exp_m) errors++;
        end
      end
      if (quiet_cycles >= WATCHDOG) begin
        $display("%0t: no progress, %0d results outstanding", $time,
                 expected_motors.size());
        $display("quad_attitude_pid_mixer_top_tb: errors");
        $finish;
      end
    end
  end

  task automatic write_gains(cfg_reg_e idx, logic [REG_W-1:0] value);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= value;
    gains_q[idx] = value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic drain();
    wait (pending_samples.size() == 0 && !s_axis_tvalid && expected_motors.size() == 0);
    repeat (20) @(negedge clk_i);
  endtask

  function automatic logic [19:0] rand_gain();
    case ($urandom_range(0, 4))
      0: return 20'd0;
      1: return 20'hFFFFF;
      default: return 20'($urandom_range(0, 655360));
    endcase
  endfunction

  initial begin
    int phase_idle [4];
    int phase_stall [4];
    phase_idle = '{0, 50, 0, 15};
    phase_stall = '{0, 0, 50, 15};
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    m_axis_tready = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = REG_ROLL_GAINS;
    cfg_wdata_i = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_off_cycles = 0;
    errors = 0;
    samples_sent = 0;
    results_seen = 0;
    quiet_cycles = 0;
    in_taken = 1'b0;
    gains_q[REG_ROLL_GAINS] = ROLL_GAINS_RST;
    gains_q[REG_PITCH_GAINS] = PITCH_GAINS_RST;
    gains_q[REG_YAW_GAINS] = YAW_GAINS_RST;
    for (int a = 0; a < 3; a++) begin
      integ_q[a] = 0;
      last_err_q[a] = 0;
    end
    heading_q = 0;
    capture_q = 1;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed samples at reset gains: off mode edges, field extremes,
    // yaw band edges, heading capture, zero and full interval, motor caps.
    pending_samples.push_back(make_sample(0, 0, 0, 0, 0, 0, 0, 1000));
    pending_samples.push_back(make_sample(5119, 1000, 1000, 0, 0, 0, 0, 1000));
    pending_samples.push_back(make_sample(5120, 0, 0, 0, 0, 0, 5000, 1000));
    pending_samples.push_back(make_sample(51200, 2048, -2048, 68, 0, 0, 9000, 1000));
    pending_samples.push_back(make_sample(51200, 2048, -2048, 69, 0, 0, 9000, 1000));
    pending_samples.push_back(make_sample(51200, 0, 0, -68, 0, 0, -7000, 1000));
    pending_samples.push_back(make_sample(51200, 0, 0, -69, 0, 0, -7000, 1000));
    pending_samples.push_back(make_sample(51200, 0, 0, 1024, 0, 0, 0, 1000));
    pending_samples.push_back(make_sample(51200, 0, 0, -1024, 0, 0, 0, 1000));
    pending_samples.push_back(make_sample(102400, ANG_MAX, ANG_MAX, 0, ANG_MAX, -ANG_MAX,
                                          ANG_MAX, 0));
    pending_samples.push_back(make_sample(102400, -ANG_MAX, -ANG_MAX, 0, -ANG_MAX, ANG_MAX,
                                          -ANG_MAX, 1048575));
    pending_samples.push_back(make_sample(131071, -1, -1, -1, -1, -1, -1, 1048575));
    pending_samples.push_back(make_sample(20000, 30000, -30000, 0, -30000, 30000, 0, 1));
    pending_samples.push_back(make_sample(7000, -30000, 30000, 0, 0, 0, 0, 3));
    pending_samples.push_back(make_sample(0, -1, -1, -1, -1, -1, -1, 1048575));
    pending_samples.push_back(make_sample(0, ANG_MAX, 0, 0, 0, 0, 0, 0));
    drain();

    // Random phases with different gain settings and idling patterns.
    for (int ph = 0; ph < 8; ph++) begin
      if (ph == 1) begin
        write_gains(REG_ROLL_GAINS, '0);
        write_gains(REG_PITCH_GAINS, '0);
        write_gains(REG_YAW_GAINS, '0);
      end else if (ph == 2) begin
        write_gains(REG_ROLL_GAINS, '1);
        write_gains(REG_PITCH_GAINS, '1);
        write_gains(REG_YAW_GAINS, '1);
      end else if (ph > 2) begin
        write_gains(REG_ROLL_GAINS, {rand_gain(), rand_gain(), rand_gain()});
        write_gains(REG_PITCH_GAINS, {rand_gain(), rand_gain(), rand_gain()});
        write_gains(REG_YAW_GAINS, {rand_gain(), rand_gain(), rand_gain()});
      end
      send_idle_pct = phase_idle[ph % 4];
      recv_stall_pct = phase_stall[ph % 4];
      for (int n = 0; n < 148; n++)
        pending_samples.push_back(rand_sample($urandom_range(0, 3) != 0));
      // Long receiver hold-off so the output backs up into the input.
      if (ph == 1) hold_off_cycles = 3000;
      drain();
    end

    $display("Ran %0d samples through %0d gain settings; %0d motor results checked.",
             samples_sent, 8, results_seen);
    if (errors == 0) begin
      $display("quad_attitude_pid_mixer_top_tb: clean");
    end else begin
      $display("quad_attitude_pid_mixer_top_tb: errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
